[src/mdb_pkg.sv]
package mdb_pkg;

    // Frame geometry: 64 x 64 pixels, up to 16 sample planes
    localparam int unsigned COORD_W    = 6;
    localparam int unsigned SAMPLE_W   = 4;
    localparam int unsigned ADDR_W     = SAMPLE_W + 2 * COORD_W;
    localparam int unsigned PLANE_W    = 2 * COORD_W;
    localparam int unsigned DEPTH_W    = 24;
    localparam int unsigned COLOR_W    = 32;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned LOG2_W     = 3;
    localparam int unsigned MAX_LOG2   = 4;
    localparam int unsigned SUM_W      = CHAN_W + SAMPLE_W;
    localparam int unsigned MIX_W      = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_FAR = '1;

    // Request codes
    localparam logic [1:0] REQ_FRAG  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [COORD_W-1:0]  pix_x;
        logic [COORD_W-1:0]  pix_y;
        logic [SAMPLE_W-1:0] sample_index;
        logic [DEPTH_W-1:0]  frag_depth;
        logic [CHAN_W-1:0]   in_red;
        logic [CHAN_W-1:0]   in_green;
        logic [CHAN_W-1:0]   in_blue;
        logic [CHAN_W-1:0]   in_alpha;
    } t_in_item;

    typedef struct packed {
        logic                depth_pass;
        logic                bad_sample;
        logic [CHAN_W-1:0]   out_red;
        logic [CHAN_W-1:0]   out_green;
        logic [CHAN_W-1:0]   out_blue;
    } t_out_item;

    // Exact v / 255 for v below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [MIX_W-1:0] v);
        logic [MIX_W:0] t;
        t = 17'(v) + 17'd1 + 17'(v[MIX_W-1:CHAN_W]);
        return t[MIX_W-1:CHAN_W];
    endfunction

endpackage

[src/mdb_ram.sv]
module mdb_ram #(
    parameter int unsigned DATA_W = 32,
    parameter int unsigned ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/msaa_depth_blend_pixel_store.sv]
// Fragment: stored depth/colour arrive (FRAG_CMP), blend written back (FRAG_WR), result
// handed over (DONE); a flagged sample or unknown request code goes straight to DONE.
// Resolve read: one of n sample planes per cycle, then RD_TAIL, RD_FIN and DONE.
// Clear: n * 4096 entries, one entry written per cycle, then DONE. Input stalled until idle.
// Reset (synchronous, active low): sweep of all 65536 entries, depth farthest, colour zero,
// input stalled until it ends. A stalled result holds the block in hand-over.
module msaa_depth_blend_pixel_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mdb_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mdb_pkg::t_out_item o_out_data,
    // sample count register
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data
);

    import mdb_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FRAG_CMP = 3'd1;  // stored depth/colour arrive
    localparam logic [2:0] S_FRAG_WR  = 3'd2;  // divide by 255, write back
    localparam logic [2:0] S_RD_LOOP  = 3'd3;  // one sample plane per cycle
    localparam logic [2:0] S_RD_TAIL  = 3'd4;  // last plane's data lands
    localparam logic [2:0] S_RD_FIN   = 3'd5;  // average by shift
    localparam logic [2:0] S_CLR      = 3'd6;  // fill sweep
    localparam logic [2:0] S_DONE     = 3'd7;  // hand result to output register

    logic [2:0]          r_state;
    logic [LOG2_W-1:0]   r_log2;
    t_in_item            r_req;
    logic [ADDR_W-1:0]   r_addr;
    t_out_item           r_res;
    t_out_item           r_out;
    logic                r_out_vld;

    // resolve
    logic [SAMPLE_W-1:0] r_cnt;
    logic                r_acc_en;
    logic [SUM_W-1:0]    r_sum_r, r_sum_g, r_sum_b;

    // fragment blend
    logic                r_pass;
    logic [MIX_W-1:0]    r_mix_r, r_mix_g, r_mix_b;

    // fill sweep
    logic [ADDR_W-1:0]   r_sweep;
    logic [ADDR_W-1:0]   r_last;
    logic [DEPTH_W-1:0]  r_fill_depth;
    logic [COLOR_W-1:0]  r_fill_color;
    logic                r_clr_reply;   // sweep belongs to a clear request

    logic [LOG2_W-1:0]   w_l;
    logic [SAMPLE_W-1:0] w_nm1;
    logic                w_bad;
    logic                w_accept;
    logic                w_out_free;

    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [ADDR_W-1:0]   w_raddr;
    logic [DEPTH_W-1:0]  w_depth_wd;
    logic [COLOR_W-1:0]  w_color_wd;
    logic [DEPTH_W-1:0]  w_depth_q;
    logic [COLOR_W-1:0]  w_color_q;

    logic [CHAN_W-1:0]   w_old_r, w_old_g, w_old_b;
    logic [CHAN_W-1:0]   w_inv_a;

    // Active sample count saturates at 16 (log2 above four)
    assign w_l   = (r_log2 > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : r_log2;
    assign w_nm1 = SAMPLE_W'((5'd1 << w_l) - 5'd1);
    assign w_bad = i_in_data.sample_index > w_nm1;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Every coordinate the 6-bit fields can carry lies inside the 64 x 64 frame,
    // so the address is simply {sample, y, x}.
    always_comb begin
        case (r_state)
            S_IDLE:    w_raddr = {i_in_data.sample_index, i_in_data.pix_y, i_in_data.pix_x};
            S_RD_LOOP: w_raddr = {r_cnt, r_req.pix_y, r_req.pix_x};
            default:   w_raddr = r_addr;
        endcase
    end

    assign w_old_r = w_color_q[7:0];
    assign w_old_g = w_color_q[15:8];
    assign w_old_b = w_color_q[23:16];
    assign w_inv_a = 8'd255 - r_req.in_alpha;

    // Write port: blend write-back or fill sweep, never both
    assign w_we       = (r_state == S_CLR) || (r_state == S_FRAG_WR && r_pass);
    assign w_waddr    = (r_state == S_CLR) ? r_sweep : r_addr;
    assign w_depth_wd = (r_state == S_CLR) ? r_fill_depth : r_req.frag_depth;
    assign w_color_wd = (r_state == S_CLR) ? r_fill_color
                      : {r_req.in_alpha, div255(r_mix_b), div255(r_mix_g), div255(r_mix_r)};

    mdb_ram #(.DATA_W(DEPTH_W), .ADDR_W(ADDR_W)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_depth_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_depth_q)
    );

    mdb_ram #(.DATA_W(COLOR_W), .ADDR_W(ADDR_W)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_color_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_color_q)
    );

    // Sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_log2       <= '0;
            r_out_vld    <= 1'b0;
            r_acc_en     <= 1'b0;
            r_sweep      <= '0;
            r_last       <= '1;
            r_fill_depth <= DEPTH_FAR;
            r_fill_color <= '0;
            r_clr_reply  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_log2 <= i_cfg_data;
            end

            // loaded from hand-over, held while the sink stalls
            r_out_vld <= (r_state == S_DONE && w_out_free) || (r_out_vld && i_out_stall);

            r_acc_en <= (r_state == S_RD_LOOP);

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in_data.req_type)
                            REQ_FRAG: begin
                                if (w_bad) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_FRAG_CMP;
                                end
                            end
                            REQ_READ: begin
                                r_cnt   <= '0;
                                r_state <= S_RD_LOOP;
                            end
                            REQ_CLEAR: begin
                                r_sweep      <= '0;
                                r_last       <= {w_nm1, {PLANE_W{1'b1}}};
                                r_fill_depth <= i_in_data.frag_depth;
                                r_fill_color <= {i_in_data.in_alpha, i_in_data.in_blue,
                                                 i_in_data.in_green, i_in_data.in_red};
                                r_clr_reply  <= 1'b1;
                                r_state      <= S_CLR;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FRAG_CMP: r_state <= S_FRAG_WR;
                S_FRAG_WR:  r_state <= S_DONE;
                S_RD_LOOP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == w_nm1) begin
                        r_state <= S_RD_TAIL;
                    end
                end
                S_RD_TAIL:  r_state <= S_RD_FIN;
                S_RD_FIN:   r_state <= S_DONE;
                S_CLR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == r_last) begin
                        r_state     <= r_clr_reply ? S_DONE : S_IDLE;
                        r_clr_reply <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: request capture, blend products, resolve sums, result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_in_data;
            r_addr  <= {i_in_data.sample_index, i_in_data.pix_y, i_in_data.pix_x};
            r_res   <= '{depth_pass: 1'b0,
                         bad_sample: (i_in_data.req_type == REQ_FRAG) && w_bad,
                         out_red:    '0,
                         out_green:  '0,
                         out_blue:   '0};
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
        end

        // less-or-equal depth test; products of the blend, rounding term folded in
        if (r_state == S_FRAG_CMP) begin
            r_pass  <= r_req.frag_depth <= w_depth_q;
            r_mix_r <= 16'(r_req.in_red)   * 16'(r_req.in_alpha)
                     + 16'(w_old_r) * 16'(w_inv_a) + 16'd127;
            r_mix_g <= 16'(r_req.in_green) * 16'(r_req.in_alpha)
                     + 16'(w_old_g) * 16'(w_inv_a) + 16'd127;
            r_mix_b <= 16'(r_req.in_blue)  * 16'(r_req.in_alpha)
                     + 16'(w_old_b) * 16'(w_inv_a) + 16'd127;
        end

        if (r_state == S_FRAG_WR) begin
            r_res.depth_pass <= r_pass;
        end

        if (r_acc_en) begin
            r_sum_r <= r_sum_r + SUM_W'(w_color_q[7:0]);
            r_sum_g <= r_sum_g + SUM_W'(w_color_q[15:8]);
            r_sum_b <= r_sum_b + SUM_W'(w_color_q[23:16]);
        end

        // sample count is a power of two: average is a shift
        if (r_state == S_RD_FIN) begin
            {r_res.out_red, r_res.out_green, r_res.out_blue} <=
                {CHAN_W'(r_sum_r >> w_l), CHAN_W'(r_sum_g >> w_l), CHAN_W'(r_sum_b >> w_l)};
        end

        if (r_state == S_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    // Checks
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result presented outside the hand-over state");

    a_pass_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.depth_pass && o_out_data.bad_sample))
        else $error("flagged sample reported as written");

    a_resolve_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_TAIL) |-> (r_cnt == SAMPLE_W'(w_nm1 + 1'b1)))
        else $error("resolve read the wrong number of planes");

    a_sweep_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> (o_in_stall || $past(r_sweep == r_last)))
        else $error("input taken during fill sweep");

endmodule
